FILE: hdl/smc_pkg.sv
// shared types, constants and helpers for the sample mean and covariance block
package smc_pkg;

  localparam int MAX_POINTS  = 256;
  localparam int MAX_DIM     = 6;
  localparam int STORE_DEPTH = MAX_POINTS * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int DIM_W       = 3;
  localparam int IDX_W       = 3;
  localparam int COORD_W     = 16;
  localparam int VAL_W       = 32;
  localparam int ACC_W       = 56;
  localparam int DEV_W       = COORD_W + 1;
  localparam int PROD_W      = 2 * DEV_W;
  localparam int DIV_CNT_W   = $clog2(ACC_W + 1);

  typedef enum logic [1:0] {
    KIND_MEAN = 2'd0,
    KIND_COV  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_EMPTY    = 2'd1,
    ERR_PARTIAL  = 2'd2,
    ERR_OVERFLOW = 2'd3
  } err_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_NDIV,
    BK_NWAIT,
    BK_ERR,
    BK_MSUM,
    BK_MDIV,
    BK_MWAIT,
    BK_MOUT,
    BK_CLOADR,
    BK_CLOADC,
    BK_CSUM,
    BK_CDIV,
    BK_CWAIT,
    BK_COUT
  } bk_state_e;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [DIM_W-1:0] dim;
    logic             ovf;
  } job_t;

  typedef struct packed {
    kind_e                   kind;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        column;
    logic signed [VAL_W-1:0] value;
    err_e                    error_code;
    logic                    last;
  } result_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic hi_same;
    hi_same = (v[ACC_W-1:VAL_W-1] == '0) || (v[ACC_W-1:VAL_W-1] == '1);
    if (hi_same) begin
      return v[VAL_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end
  endfunction

endpackage

FILE: hdl/smc_ram.sv
// generic single write, single registered read ram
module smc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/smc_front.sv
// front end: takes coordinates, fills the point store, hands off one job per set
module smc_front import smc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [COORD_W-1:0] coordinate_i,
  input  logic               end_of_set_i,
  input  logic               dim_we_i,
  input  logic [DIM_W-1:0]   dim_i,
  input  logic               set_done_i,
  output logic               full_o,
  output logic               jq_push_o,
  output job_t               jq_job_o,
  output logic               we_o,
  output logic [ADDR_W-1:0]  waddr_o,
  output logic [COORD_W-1:0] wdata_o
);

  logic [DIM_W-1:0] dim_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             busy_q, busy_d;
  logic             accept, room;
  logic [DIM_W-1:0] dim_c;

  assign accept = push_i && !busy_q;
  assign room   = count_q < CNT_W'(STORE_DEPTH);
  assign full_o = busy_q;

  always_comb begin
    if (dim_q == '0) begin
      dim_c = DIM_W'(1);
    end else if (dim_q > DIM_W'(MAX_DIM)) begin
      dim_c = DIM_W'(MAX_DIM);
    end else begin
      dim_c = dim_q;
    end
  end

  assign we_o    = accept && room;
  assign waddr_o = count_q[ADDR_W-1:0];
  assign wdata_o = coordinate_i;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    busy_d  = busy_q;
    if (set_done_i) begin
      busy_d = 1'b0;
    end
    if (accept) begin
      if (room) begin
        count_d = count_q + CNT_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    jq_job_o.count = count_d;
    jq_job_o.dim   = dim_c;
    jq_job_o.ovf   = ovf_d;
    jq_push_o      = accept && end_of_set_i;
    if (jq_push_o) begin
      count_d = '0;
      ovf_d   = 1'b0;
      busy_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q   <= DIM_W'(2);
      count_q <= '0;
      ovf_q   <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      if (dim_we_i) begin
        dim_q <= dim_i;
      end
      count_q <= count_d;
      ovf_q   <= ovf_d;
      busy_q  <= busy_d;
    end
  end

endmodule

FILE: hdl/smc_jobq.sv
// two-entry job queue between front and back
module smc_jobq import smc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  job_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign empty_o = cnt_q == 2'd0;
  assign do_pop  = pop_i && !empty_o;
  assign do_push = push_i && (cnt_q != 2'd2);
  assign job_o   = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wp_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wp_q <= !wp_q;
      end
      if (do_pop) begin
        rp_q <= !rp_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

FILE: hdl/smc_div.sv
// shared iterative signed divider, one quotient bit per cycle
module smc_div import smc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ACC_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]        divisor_i,
  output logic                    done_o,
  output logic signed [ACC_W-1:0] quotient_o,
  output logic                    rem_nz_o
);

  logic [ACC_W-1:0]     q_q;
  logic [CNT_W-1:0]     r_q, d_q;
  logic                 neg_q, busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [CNT_W:0]       trial, diff;
  logic                 ge;

  assign trial = {r_q, q_q[ACC_W-1]};
  assign diff  = trial - {1'b0, d_q};
  assign ge    = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= dividend_i[ACC_W-1] ? -dividend_i : dividend_i;
      r_q   <= '0;
      d_q   <= divisor_i;
      neg_q <= dividend_i[ACC_W-1];
    end else if (busy_q) begin
      q_q <= {q_q[ACC_W-2:0], ge};
      r_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(ACC_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(q_q) : $signed(q_q);
  assign rem_nz_o   = r_q != '0;

endmodule

FILE: hdl/smc_back.sv
// back end: sums over the stored set, divides, emits mean then covariance, or a single error beat
module smc_back import smc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    jq_empty_i,
  input  job_t                    jq_job_i,
  output logic                    jq_pop_o,
  output logic [ADDR_W-1:0]       raddr_a_o,
  output logic [ADDR_W-1:0]       raddr_b_o,
  input  logic [COORD_W-1:0]      rdata_a_i,
  input  logic [COORD_W-1:0]      rdata_b_i,
  output logic                    div_start_o,
  output logic signed [ACC_W-1:0] div_dividend_o,
  output logic [CNT_W-1:0]        div_divisor_o,
  input  logic                    div_done_i,
  input  logic signed [ACC_W-1:0] div_quot_i,
  input  logic                    div_rem_nz_i,
  output logic                    set_done_o,
  input  logic                    pop_i,
  output logic                    empty_o,
  output result_t                 res_o
);

  bk_state_e state_q, state_d;
  job_t      job_q;
  logic [CNT_W-1:0] n_q, p_q, nq;
  logic [IDX_W-1:0] row_q, col_q, last_idx;
  logic [ADDR_W-1:0] addr_a_q, addr_b_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [DEV_W-1:0]  dev_a, dev_b;
  logic [COORD_W-1:0] mean_q [MAX_DIM];
  logic [COORD_W-1:0] mr_q, mc_q, mean_sel;
  logic signed [VAL_W-1:0] val_q;
  logic    v1_q, v2_q, out_vld_q;
  result_t out_q, res_c;
  logic    res_ready, emit, issue, more, cov_last;
  err_e    err_c;
  // error code is latched when the count division finishes
  err_e    err_q;

  assign nq        = div_quot_i[CNT_W-1:0];
  assign last_idx  = IDX_W'(job_q.dim - DIM_W'(1));
  assign more      = p_q < n_q;
  assign res_ready = !out_vld_q || pop_i;
  assign cov_last  = (row_q == last_idx) && (col_q == last_idx);
  assign mean_sel  = mean_q[(state_q == BK_CLOADR) ? row_q : col_q];
  assign dev_a     = $signed({rdata_a_i[COORD_W-1], rdata_a_i}) - $signed({mr_q[COORD_W-1], mr_q});
  assign dev_b     = $signed({rdata_b_i[COORD_W-1], rdata_b_i}) - $signed({mc_q[COORD_W-1], mc_q});
  assign raddr_a_o = addr_a_q;
  assign raddr_b_o = addr_b_q;

  always_comb begin
    if (job_q.ovf) begin
      err_c = ERR_OVERFLOW;
    end else if (div_rem_nz_i) begin
      err_c = ERR_PARTIAL;
    end else if (nq == '0) begin
      err_c = ERR_EMPTY;
    end else begin
      err_c = ERR_NONE;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:   if (!jq_empty_i) state_d = BK_NDIV;
      BK_NDIV:   state_d = BK_NWAIT;
      BK_NWAIT:  if (div_done_i) state_d = (err_c != ERR_NONE) ? BK_ERR : BK_MSUM;
      BK_ERR:    if (res_ready) state_d = BK_IDLE;
      BK_MSUM:   if (!more && !v1_q) state_d = BK_MDIV;
      BK_MDIV:   state_d = BK_MWAIT;
      BK_MWAIT:  if (div_done_i) state_d = BK_MOUT;
      BK_MOUT:   if (res_ready) state_d = (row_q == last_idx) ? BK_CLOADR : BK_MSUM;
      BK_CLOADR: state_d = BK_CLOADC;
      BK_CLOADC: state_d = BK_CSUM;
      BK_CSUM:   if (!more && !v1_q && !v2_q) state_d = BK_CDIV;
      BK_CDIV:   state_d = BK_CWAIT;
      BK_CWAIT:  if (div_done_i) state_d = BK_COUT;
      BK_COUT:   if (res_ready) state_d = cov_last ? BK_IDLE : BK_CLOADR;
      default:   state_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    jq_pop_o       = (state_q == BK_IDLE) && !jq_empty_i;
    div_start_o    = 1'b0;
    div_dividend_o = acc_q;
    div_divisor_o  = n_q;
    issue          = 1'b0;
    emit           = 1'b0;
    res_c          = '{kind: KIND_ERR, row: '0, column: '0, value: '0,
                       error_code: ERR_NONE, last: 1'b0};
    case (state_q)
      BK_NDIV: begin
        div_start_o    = 1'b1;
        div_dividend_o = ACC_W'(job_q.count);
        div_divisor_o  = CNT_W'(job_q.dim);
      end
      BK_MDIV, BK_CDIV: div_start_o = 1'b1;
      BK_MSUM, BK_CSUM: issue = more;
      BK_ERR: begin
        emit             = res_ready;
        res_c.error_code = err_q;
        res_c.last       = 1'b1;
      end
      BK_MOUT: begin
        emit       = res_ready;
        res_c.kind = KIND_MEAN;
        res_c.row  = row_q;
        res_c.value = val_q;
      end
      BK_COUT: begin
        emit         = res_ready;
        res_c.kind   = KIND_COV;
        res_c.row    = row_q;
        res_c.column = col_q;
        res_c.value  = val_q;
        res_c.last   = cov_last;
      end
      default: ;
    endcase
    set_done_o = emit && res_c.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      out_vld_q <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= issue;
      v2_q    <= (state_q == BK_CSUM) && v1_q;
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (jq_pop_o) begin
      job_q <= jq_job_i;
    end
    if (emit) begin
      out_q <= res_c;
    end
    case (state_q)
      BK_NWAIT: begin
        if (div_done_i) begin
          n_q      <= nq;
          err_q    <= err_c;
          row_q    <= '0;
          col_q    <= '0;
          p_q      <= '0;
          acc_q    <= '0;
          addr_a_q <= '0;
        end
      end
      BK_MSUM: begin
        if (issue) begin
          p_q      <= p_q + CNT_W'(1);
          addr_a_q <= addr_a_q + ADDR_W'(job_q.dim);
        end
        if (v1_q) begin
          acc_q <= acc_q + ACC_W'($signed(rdata_a_i));
        end
      end
      BK_MWAIT: begin
        if (div_done_i) begin
          mean_q[row_q] <= div_quot_i[COORD_W-1:0];
          val_q <= VAL_W'($signed(div_quot_i[COORD_W-1:0]));
        end
      end
      BK_MOUT: begin
        if (emit) begin
          if (row_q == last_idx) begin
            row_q <= '0;
            col_q <= '0;
          end else begin
            row_q    <= row_q + IDX_W'(1);
            p_q      <= '0;
            acc_q    <= '0;
            addr_a_q <= ADDR_W'(row_q) + ADDR_W'(1);
          end
        end
      end
      BK_CLOADR: mr_q <= mean_sel;
      BK_CLOADC: begin
        mc_q     <= mean_sel;
        p_q      <= '0;
        acc_q    <= '0;
        addr_a_q <= ADDR_W'(row_q);
        addr_b_q <= ADDR_W'(col_q);
      end
      BK_CSUM: begin
        if (issue) begin
          p_q      <= p_q + CNT_W'(1);
          addr_a_q <= addr_a_q + ADDR_W'(job_q.dim);
          addr_b_q <= addr_b_q + ADDR_W'(job_q.dim);
        end
        if (v1_q) begin
          prod_q <= dev_a * dev_b;
        end
        if (v2_q) begin
          acc_q <= acc_q + ACC_W'(prod_q);
        end
      end
      BK_CWAIT: begin
        if (div_done_i) begin
          val_q <= sat32(div_quot_i);
        end
      end
      BK_COUT: begin
        if (emit) begin
          if (col_q == last_idx) begin
            col_q <= '0;
            row_q <= row_q + IDX_W'(1);
          end else begin
            col_q <= col_q + IDX_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign empty_o = !out_vld_q;
  assign res_o   = out_q;

  // summing passes only run over a non-empty set
  a_sum_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_MSUM || state_q == BK_CSUM) |-> n_q != '0)
    else $error("summing pass over an empty set");

  // point counter never passes the point count
  a_point_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_MSUM || state_q == BK_CSUM) |-> p_q <= n_q)
    else $error("point counter beyond point count");

  // a result is only produced into a free output slot
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_vld_q || pop_i))
    else $error("result register overwritten");

  // a finished set always ends on a last beat
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    set_done_o |=> (out_vld_q && out_q.last))
    else $error("set finished without last beat");

endmodule

FILE: hdl/sample_mean_covariance.sv
// top level of the sample mean and covariance block
//
// input channel: coordinates of a point set, q8.8, one per beat, point after
// point; push a beat while full is low. end_of_set_i marks the final beat.
// one coordinate is taken per cycle while the set is loading.
// output channel: results appear while empty is low and are taken with pop.
// a set gives dim mean beats then dim*dim covariance beats (row by row, q16.16,
// saturated), or a single error beat. last_o marks the final beat of a set.
// after end_of_set, full stays high until the final beat of the set has been
// produced; the back end walks the stored set once per mean entry and once per
// covariance entry (after loading the row and column means), and each result
// also waits for a division, as does the point count up front.
// a stalled receiver simply holds the back end; the front end is not affected
// until the next set arrives.
// reset sets dimension to 2 and empties both sides; the point store holds no
// state worth clearing, as only entries of the current set are read.
// dimension_i is written with dimension_we_i; 0 acts as 1, above 6 as 6.
module sample_mean_covariance import smc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [COORD_W-1:0]      coordinate_i,
  input  logic                    end_of_set_i,
  output logic                    empty,
  input  logic                    pop,
  output logic [1:0]              kind_o,
  output logic [IDX_W-1:0]        row_o,
  output logic [IDX_W-1:0]        column_o,
  output logic signed [VAL_W-1:0] value_o,
  output logic [1:0]              error_code_o,
  output logic                    last_o,
  input  logic                    dimension_we_i,
  input  logic [DIM_W-1:0]        dimension_i
);

  // front to store and job queue
  logic               we;
  logic [ADDR_W-1:0]  waddr, raddr_a, raddr_b;
  logic [COORD_W-1:0] wdata, rdata_a, rdata_b;
  logic               jq_push, jq_pop, jq_empty, set_done;
  job_t               jq_in, jq_out;

  // shared divider
  logic                    div_start, div_done, div_rem_nz;
  logic signed [ACC_W-1:0] div_dividend, div_quot;
  logic [CNT_W-1:0]        div_divisor;
  result_t                 res;

  smc_front u_front (
    .clk_i, .rst_ni,
    .push_i       (push),
    .coordinate_i,
    .end_of_set_i,
    .dim_we_i     (dimension_we_i),
    .dim_i        (dimension_i),
    .set_done_i   (set_done),
    .full_o       (full),
    .jq_push_o    (jq_push),
    .jq_job_o     (jq_in),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata)
  );

  // two copies of the store so a row and a column coordinate read together
  smc_ram #(.WIDTH(COORD_W), .DEPTH(STORE_DEPTH)) u_store_a (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr_a), .rdata_o(rdata_a)
  );

  smc_ram #(.WIDTH(COORD_W), .DEPTH(STORE_DEPTH)) u_store_b (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr_b), .rdata_o(rdata_b)
  );

  smc_jobq u_jobq (
    .clk_i, .rst_ni,
    .push_i  (jq_push),
    .job_i   (jq_in),
    .pop_i   (jq_pop),
    .empty_o (jq_empty),
    .job_o   (jq_out)
  );

  smc_div u_div (
    .clk_i, .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot),
    .rem_nz_o   (div_rem_nz)
  );

  smc_back u_back (
    .clk_i, .rst_ni,
    .jq_empty_i     (jq_empty),
    .jq_job_i       (jq_out),
    .jq_pop_o       (jq_pop),
    .raddr_a_o      (raddr_a),
    .raddr_b_o      (raddr_b),
    .rdata_a_i      (rdata_a),
    .rdata_b_i      (rdata_b),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_done_i     (div_done),
    .div_quot_i     (div_quot),
    .div_rem_nz_i   (div_rem_nz),
    .set_done_o     (set_done),
    .pop_i          (pop),
    .empty_o        (empty),
    .res_o          (res)
  );

  // result fields out to their own ports
  assign kind_o       = res.kind;
  assign row_o        = res.row;
  assign column_o     = res.column;
  assign value_o      = res.value;
  assign error_code_o = res.error_code;
  assign last_o       = res.last;

endmodule
